// ===== design/ecpf_pkg.sv =====
// shared constants, types and helpers of the escaped checksum packet framer
package ecpf_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hE0;
    localparam logic [7:0] ESC_BYTE  = 8'hD0;
    localparam logic [7:0] MAX_LEN   = 8'd254;

    // configuration register indexes
    localparam logic CFG_DEST   = 1'b0;
    localparam logic CFG_SOURCE = 1'b1;

    // byte units of one item, in send order
    localparam int NUM_UNITS  = 7;
    localparam int UNIT_IDX_W = $clog2(NUM_UNITS);

    typedef logic [UNIT_IDX_W-1:0] t_unit_idx;
    typedef logic [NUM_UNITS-1:0]  t_unit_mask;

    localparam t_unit_idx U_SYNC   = 3'd0;
    localparam t_unit_idx U_DEST   = 3'd1;
    localparam t_unit_idx U_SOURCE = 3'd2;
    localparam t_unit_idx U_LEN    = 3'd3;
    localparam t_unit_idx U_CMD    = 3'd4;
    localparam t_unit_idx U_PAY    = 3'd5;
    localparam t_unit_idx U_CSUM   = 3'd6;

    typedef struct packed {
        logic       open;
        logic [7:0] bytes_left;
        logic [7:0] sum;
    } t_frame_state;

    typedef struct packed {
        t_unit_mask                  mask;
        logic [NUM_UNITS-1:0][7:0]   units;
    } t_unit_set;

    function automatic logic needs_escape(input logic [7:0] b);
        return (b == ESC_BYTE) || (b == SYNC_BYTE);
    endfunction

endpackage

// ===== design/ecpf_expand.sv =====
// expands one input item into its byte units and the next frame state
module ecpf_expand (
    input  ecpf_pkg::t_frame_state i_state,
    input  logic [7:0]             i_dest_node,
    input  logic [7:0]             i_source_node,
    input  logic [7:0]             i_payload_byte,
    input  logic [7:0]             i_frame_len,
    input  logic [7:0]             i_command_code,
    output ecpf_pkg::t_unit_set    o_units,
    output ecpf_pkg::t_frame_state o_state
);

    logic [7:0] len;
    logic [7:0] len_p1;
    logic [7:0] hdr_sum;
    logic [7:0] new_sum;
    logic [7:0] left;

    always_comb begin
        len     = (i_frame_len > ecpf_pkg::MAX_LEN) ? ecpf_pkg::MAX_LEN : i_frame_len;
        len_p1  = len + 8'd1;
        hdr_sum = i_dest_node + i_source_node + len_p1 + i_command_code;
        new_sum = '0;
        left    = '0;

        o_units.mask                           = '0;
        o_units.units[ecpf_pkg::U_SYNC]        = ecpf_pkg::SYNC_BYTE;
        o_units.units[ecpf_pkg::U_DEST]        = i_dest_node;
        o_units.units[ecpf_pkg::U_SOURCE]      = i_source_node;
        o_units.units[ecpf_pkg::U_LEN]         = len_p1;
        o_units.units[ecpf_pkg::U_CMD]         = i_command_code;
        o_units.units[ecpf_pkg::U_PAY]         = i_payload_byte;
        o_units.units[ecpf_pkg::U_CSUM]        = '0;

        if (!i_state.open) begin
            o_units.mask[ecpf_pkg::U_SYNC]   = 1'b1;
            o_units.mask[ecpf_pkg::U_DEST]   = 1'b1;
            o_units.mask[ecpf_pkg::U_SOURCE] = 1'b1;
            o_units.mask[ecpf_pkg::U_LEN]    = 1'b1;
            o_units.mask[ecpf_pkg::U_CMD]    = 1'b1;
            if (len == 8'd0) begin
                // empty frame: header and checksum only
                new_sum = hdr_sum;
                left    = '0;
            end else begin
                new_sum = hdr_sum + i_payload_byte;
                left    = len - 8'd1;
                o_units.mask[ecpf_pkg::U_PAY] = 1'b1;
            end
        end else begin
            new_sum = i_state.sum + i_payload_byte;
            left    = i_state.bytes_left - 8'd1;
            o_units.mask[ecpf_pkg::U_PAY] = 1'b1;
        end

        o_units.units[ecpf_pkg::U_CSUM] = new_sum;
        o_units.mask[ecpf_pkg::U_CSUM]  = (left == 8'd0);

        o_state.open       = (left != 8'd0);
        o_state.bytes_left = left;
        o_state.sum        = new_sum;
    end

endmodule

// ===== design/escaped_checksum_packet_framer_top.sv =====
// Escaped checksum packet framer. Each accepted item is expanded into byte units (sync,
// header, payload, checksum) held in one register stage; a serializer sends them, escaping
// 0xD0 and 0xE0 as 0xD0 plus the byte minus one, one byte per cycle into an output register
// while it is free or the receiver takes its byte. An item causes 1 or 2 output bytes for a
// payload byte in an open frame, up to 4 when it also carries the checksum, and up to 13 for
// the item that opens a frame. The next item is taken in the cycle the last byte of the
// current one moves to the output register, so there is no gap. The first byte of an item
// is held in the unit register and then in the output register. Writes to dest_node
// (index 0) and source_node (index 1) take effect for headers of later frames.
module escaped_checksum_packet_framer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_payload_byte,
    input  logic [7:0] i_frame_len,
    input  logic [7:0] i_command_code,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end,
    output logic       o_run_last
);

    logic [7:0]                      r_dest;
    logic [7:0]                      r_source;
    ecpf_pkg::t_frame_state          r_state;
    ecpf_pkg::t_unit_mask            r_mask;
    logic [ecpf_pkg::NUM_UNITS-1:0][7:0] r_units;
    logic                            r_phase;
    logic                            r_out_valid;
    logic [7:0]                      r_out_byte;
    logic                            r_out_frame_end;
    logic                            r_out_run_last;

    ecpf_pkg::t_unit_set             exp_units;
    ecpf_pkg::t_frame_state          n_state;

    ecpf_pkg::t_unit_idx             cur_idx;
    logic [7:0]                      cur_byte;
    logic                            cur_esc;
    logic                            unit_done;
    logic [7:0]                      ser_byte;
    ecpf_pkg::t_unit_mask            n_mask;
    logic                            ser_run_last;
    logic                            ser_frame_end;
    logic                            buf_move;
    logic                            in_fire;

    ecpf_expand u_expand (
        .i_state        (r_state),
        .i_dest_node    (r_dest),
        .i_source_node  (r_source),
        .i_payload_byte (i_payload_byte),
        .i_frame_len    (i_frame_len),
        .i_command_code (i_command_code),
        .o_units        (exp_units),
        .o_state        (n_state)
    );

    // lowest pending unit goes first
    always_comb begin
        cur_idx = ecpf_pkg::U_SYNC;
        for (int k = ecpf_pkg::NUM_UNITS - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                cur_idx = ecpf_pkg::t_unit_idx'(k);
            end
        end
    end

    always_comb begin
        cur_byte      = r_units[cur_idx];
        cur_esc       = (cur_idx != ecpf_pkg::U_SYNC) && ecpf_pkg::needs_escape(cur_byte);
        unit_done     = r_phase || !cur_esc;
        ser_byte      = r_phase ? (cur_byte - 8'd1) : (cur_esc ? ecpf_pkg::ESC_BYTE : cur_byte);
        n_mask        = r_mask & ~(ecpf_pkg::t_unit_mask'(1) << cur_idx);
        ser_run_last  = unit_done && (n_mask == '0);
        ser_frame_end = unit_done && (cur_idx == ecpf_pkg::U_CSUM);
    end

    assign buf_move   = (r_mask != '0) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_mask == '0) || (buf_move && ser_run_last);
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest   <= '0;
            r_source <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ecpf_pkg::CFG_DEST:   r_dest   <= i_cfg_data;
                ecpf_pkg::CFG_SOURCE: r_source <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_mask  <= '0;
            r_phase <= 1'b0;
        end else if (in_fire) begin
            r_state <= n_state;
            r_mask  <= exp_units.mask;
            r_phase <= 1'b0;
        end else if (buf_move) begin
            if (unit_done) begin
                r_mask  <= n_mask;
                r_phase <= 1'b0;
            end else begin
                r_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_units <= exp_units.units;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (buf_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_move) begin
            r_out_byte      <= ser_byte;
            r_out_frame_end <= ser_frame_end;
            r_out_run_last  <= ser_run_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_frame_end = r_out_frame_end;
    assign o_run_last  = r_out_run_last;

    // the checksum byte always ends the item's transfers
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |-> o_run_last)
        else $error("frame end without run last");

    // second byte of an escape only while a unit is pending
    a_phase_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_mask != '0))
        else $error("escape phase with no pending unit");

    a_open_has_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.open |-> (r_state.bytes_left != 8'd0))
        else $error("open frame with no bytes left");

    a_closed_no_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.open |-> (r_state.bytes_left == 8'd0))
        else $error("closed frame with bytes left");

    // a new item only lands once the previous one is fully handed on
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (r_mask == '0) || (buf_move && ser_run_last))
        else $error("item accepted over pending bytes");

endmodule

// ===== test/testbench.sv =====
// testbench for the escaped checksum packet framer: directed and random frames checked byte by byte
`timescale 1ns / 1ps

module testbench;

    localparam int DRAIN_SLACK = 20;

    typedef struct packed {
        logic [7:0] value;
        logic       frame_end;
        logic       run_last;
    } t_framed_byte;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_index;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_payload_byte;
    logic [7:0] i_frame_len;
    logic [7:0] i_command_code;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic       o_frame_end;
    logic       o_run_last;

    // predicted framer state and node ids
    logic       pred_open;
    logic [7:0] pred_left;
    logic [7:0] pred_sum;
    logic [7:0] node_dest;
    logic [7:0] node_src;

    t_framed_byte expected_bytes[$];
    t_framed_byte want_byte;

    int  error_count;
    int  items_sent;
    bit  no_idle;
    int  hold_request;
    int  hold_left;

    escaped_checksum_packet_framer_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_payload_byte (i_payload_byte),
        .i_frame_len    (i_frame_len),
        .i_command_code (i_command_code),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_frame_end    (o_frame_end),
        .o_run_last     (o_run_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------- expected byte stream ----------------

    task automatic push_byte(input logic [7:0] b);
        t_framed_byte e;
        e.value     = b;
        e.frame_end = 1'b0;
        e.run_last  = 1'b0;
        expected_bytes.push_back(e);
    endtask

    task automatic push_escaped(input logic [7:0] b);
        if (b == ecpf_pkg::ESC_BYTE || b == ecpf_pkg::SYNC_BYTE) begin
            push_byte(ecpf_pkg::ESC_BYTE);
            push_byte(b - 8'd1);
        end else begin
            push_byte(b);
        end
    endtask

    task automatic push_summed(input logic [7:0] b);
        pred_sum = pred_sum + b;
        push_escaped(b);
    endtask

    task automatic close_frame();
        t_framed_byte e;
        push_escaped(pred_sum);
        e = expected_bytes.pop_back();
        e.frame_end = 1'b1;
        expected_bytes.push_back(e);
        pred_open = 1'b0;
        pred_left = 8'd0;
    endtask

    task automatic frame_item(input logic [7:0] pay, input logic [7:0] len,
                              input logic [7:0] cmd);
        logic [7:0]   n;
        bit           closed;
        t_framed_byte e;
        closed = 0;
        if (!pred_open) begin
            n = (len > ecpf_pkg::MAX_LEN) ? ecpf_pkg::MAX_LEN : len;
            pred_sum = 8'd0;
            push_byte(ecpf_pkg::SYNC_BYTE);
            push_summed(node_dest);
            push_summed(node_src);
            push_summed(n + 8'd1);
            push_summed(cmd);
            if (n == 8'd0) begin
                // zero length: header and checksum only, payload dropped
                close_frame();
                closed = 1;
            end else begin
                pred_open = 1'b1;
                pred_left = n;
            end
        end
        if (!closed) begin
            push_summed(pay);
            if (pred_left > 8'd0) pred_left = pred_left - 8'd1;
            if (pred_left == 8'd0) close_frame();
        end
        e = expected_bytes.pop_back();
        e.run_last = 1'b1;
        expected_bytes.push_back(e);
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h", o_out_byte));
            end else begin
                want_byte = expected_bytes.pop_front();
                if (o_out_byte !== want_byte.value)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              o_out_byte, want_byte.value));
                if (o_frame_end !== want_byte.frame_end)
                    report_mismatch($sformatf("frame_end %b, expected %b",
                                              o_frame_end, want_byte.frame_end));
                if (o_run_last !== want_byte.run_last)
                    report_mismatch($sformatf("run_last %b, expected %b",
                                              o_run_last, want_byte.run_last));
            end
        end
    end

    // receiver: random stalls, or a long hold when one is requested
    initial begin
        i_out_ready <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (!no_idle && $urandom_range(0, 99) < 16) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return ecpf_pkg::ESC_BYTE;
        if (r < 16) return ecpf_pkg::SYNC_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 8'($urandom_range(0, 4));
        if (r < 90) return 8'($urandom_range(5, 20));
        return 8'($urandom_range(21, 100));
    endfunction

    // valid stays high into the next item unless this transfer is followed by a gap
    task automatic send_item(input logic [7:0] pay, input logic [7:0] len,
                             input logic [7:0] cmd);
        i_in_valid     <= 1'b1;
        i_payload_byte <= pay;
        i_frame_len    <= len;
        i_command_code <= cmd;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        frame_item(pay, len, cmd);
        items_sent++;
        if (!no_idle && $urandom_range(0, 99) < 16) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd);
        int count;
        count = (len > ecpf_pkg::MAX_LEN) ? int'(ecpf_pkg::MAX_LEN) : int'(len);
        send_item(pick_byte(), len, cmd);
        // length and command are don't-care while the frame is open
        for (int k = 1; k < count; k++)
            send_item(pick_byte(), 8'($urandom_range(0, 255)), pick_byte());
    endtask

    task automatic finish_burst();
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic write_node_ids(input logic [7:0] d, input logic [7:0] s);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ecpf_pkg::CFG_DEST;
        i_cfg_data  <= d;
        @(posedge i_clk);
        node_dest = d;
        i_cfg_index <= ecpf_pkg::CFG_SOURCE;
        i_cfg_data  <= s;
        @(posedge i_clk);
        node_src = s;
        i_cfg_we <= 1'b0;
    endtask

    // ---------------- tests ----------------

    task automatic test_directed();
        // zero-length frames, checksum and command landing on the escape codes
        send_item(8'hAA, 8'd0, 8'h00);
        send_item(8'h55, 8'd0, 8'hDF);
        send_item(8'h00, 8'd0, 8'hCF);
        send_item(8'hFF, 8'd0, ecpf_pkg::SYNC_BYTE);
        send_item(8'h0F, 8'd0, ecpf_pkg::ESC_BYTE);
        send_item(8'hF0, 8'd0, 8'hFF);
        // one-byte frames whose checksum needs escaping
        send_item(8'hDE, 8'd1, 8'h00);
        send_item(8'hCE, 8'd1, 8'h00);
        // escaped payload bytes, ignored fields while open
        send_item(ecpf_pkg::SYNC_BYTE, 8'd3, 8'h5A);
        send_item(ecpf_pkg::ESC_BYTE, 8'hFF, 8'hFF);
        send_item(8'hFF, 8'h00, 8'h00);
        send_item(8'h00, 8'd2, 8'hA5);
        send_item(8'h7F, 8'hAB, 8'hCD);
        finish_burst();
    endtask

    task automatic test_node_ids();
        logic [7:0] dests[5];
        logic [7:0] srcs[5];
        dests = '{8'hFF, 8'h00, 8'hFF, ecpf_pkg::SYNC_BYTE, ecpf_pkg::ESC_BYTE};
        srcs  = '{8'hFF, 8'hFF, 8'h00, ecpf_pkg::ESC_BYTE, ecpf_pkg::SYNC_BYTE};
        for (int k = 0; k < 5; k++) begin
            write_node_ids(dests[k], srcs[k]);
            send_frame(8'd0, pick_byte());
            send_frame(8'd2, pick_byte());
            finish_burst();
        end
    endtask

    task automatic test_write_mid_frame();
        write_node_ids(8'h12, 8'h34);
        send_item(8'h01, 8'd3, 8'h40);
        send_item(8'h02, 8'h00, 8'h00);
        finish_burst();
        // frame still open: new ids only show up in the next header
        write_node_ids(ecpf_pkg::SYNC_BYTE, ecpf_pkg::SYNC_BYTE);
        send_item(8'h03, 8'h00, 8'h00);
        send_item(8'h04, 8'h00, 8'h00);
        send_frame(8'd1, 8'h00);
        finish_burst();
    endtask

    task automatic test_longest_frame();
        // length above the limit saturates
        send_frame(8'd255, pick_byte());
        finish_burst();
    endtask

    task automatic test_output_stall();
        hold_request = 300;
        no_idle = 1;
        for (int k = 0; k < 8; k++)
            send_frame(8'($urandom_range(0, 3)), pick_byte());
        no_idle = 0;
        finish_burst();
    endtask

    task automatic test_random_frames();
        int start;
        for (int chunk = 0; chunk < 4; chunk++) begin
            if (chunk > 0) write_node_ids(pick_byte(), pick_byte());
            no_idle = (chunk == 2);
            start = items_sent;
            while (items_sent - start < 48)
                send_frame(pick_len(), pick_byte());
            finish_burst();
        end
        no_idle = 0;
    endtask

    initial begin
        error_count  = 0;
        items_sent   = 0;
        no_idle      = 0;
        hold_request = 0;
        pred_open    = 1'b0;
        pred_left    = 8'd0;
        pred_sum     = 8'd0;
        node_dest    = 8'd0;
        node_src     = 8'd0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= ecpf_pkg::CFG_DEST;
        i_cfg_data     <= 8'd0;
        i_in_valid     <= 1'b0;
        i_payload_byte <= 8'd0;
        i_frame_len    <= 8'd0;
        i_command_code <= 8'd0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_node_ids();
        test_write_mid_frame();
        test_longest_frame();
        test_output_stall();
        test_random_frames();
        finish_burst();

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
